### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))

`endif

### design/lrce_pkg.sv
package lrce_pkg;

  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned RAD_W    = 20;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned DIV_LAT  = FRAC_W;
  localparam int unsigned LERP_LAT = 2;
  localparam int unsigned PIPE_LAT = 1 + DIV_LAT + 2 * LERP_LAT;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam int unsigned FLAG_EXPAND = 0;
  localparam int unsigned FLAG_FLASH  = 1;
  localparam int unsigned FLAG_SHRINK = 2;

  typedef struct packed {
    logic [16:0] remaining_time;
    logic [15:0] fade_time;
    logic [15:0] peak_time;
    logic [2:0]  mode_flags;
    logic [19:0] target_radius;
    logic [19:0] start_radius;
    logic [15:0] target_red;
    logic [15:0] target_green;
    logic [15:0] target_blue;
    logic [15:0] start_red;
    logic [15:0] start_green;
    logic [15:0] start_blue;
  } in_item_t;

  typedef struct packed {
    logic [19:0] cur_radius;
    logic [15:0] cur_red;
    logic [15:0] cur_green;
    logic [15:0] cur_blue;
  } out_item_t;

endpackage

### design/lrce_div.sv
module lrce_div
  import lrce_pkg::*;
(
  input  logic              clk_i,
  input  logic [FRAC_W-1:0] num_i,
  input  logic [FRAC_W-1:0] den_i,
  output logic [FRAC_W-1:0] quo_o
);

  logic [FRAC_W:0]   rem_q [DIV_LAT];
  logic [FRAC_W-1:0] den_q [DIV_LAT];
  logic [FRAC_W-1:0] quo_q [DIV_LAT];
  logic              zero_q[DIV_LAT];

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < DIV_LAT; s++) begin : g_step
    logic [FRAC_W:0]   rem_in, rem_sh, rem_d;
    logic [FRAC_W-1:0] den_in, quo_in;
    logic              zero_in, bit_d;

    if (s == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign rem_sh  = rem_in;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign zero_in = (den_i == '0);
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign rem_sh  = {rem_in[FRAC_W-1:0], 1'b0};
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    assign bit_d = (rem_sh >= {1'b0, den_in});
    assign rem_d = bit_d ? (rem_sh - {1'b0, den_in}) : rem_sh;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_in;
      quo_q[s]  <= {quo_in[FRAC_W-2:0], bit_d};
      zero_q[s] <= zero_in;
    end
  end

  // A zero divisor reads as one
  assign quo_o = zero_q[DIV_LAT-1] ? ONE_Q16 : quo_q[DIV_LAT-1];

endmodule

### design/lrce_lerp.sv
module lrce_lerp
  import lrce_pkg::*;
(
  input  logic              clk_i,
  input  logic [RAD_W-1:0]  a_i,
  input  logic [RAD_W-1:0]  b_i,
  input  logic [FRAC_W-1:0] f_i,
  output logic [RAD_W-1:0]  y_o
);

  localparam int unsigned PW = RAD_W + FRAC_W;

  logic [PW-1:0]  pa_q, pb_q;
  logic [PW:0]    sum;
  logic [RAD_W-1:0] y_q;

  // Multiply both weights
  always_ff @(posedge clk_i) begin
    pa_q <= a_i * (ONE_Q16 - f_i);
    pb_q <= b_i * f_i;
  end

  // Add and drop the fraction bits
  assign sum = {1'b0, pa_q} + {1'b0, pb_q};

  always_ff @(posedge clk_i) begin
    y_q <= sum[RAD_W+15:16];
  end

  assign y_o = y_q;

endmodule

### design/light_radius_color_envelope_unit.sv
// Light radius and color envelope: one light per cycle, fully pipelined.
// An item is taken whenever start_i is high (busy_o stays low); done_o marks
// its result, which passes through the input register, 17 stages of
// the bit-per-stage fraction dividers, two multiply/add stages of radius and
// color interpolation and two of fade scaling. The receiver cannot stall, and
// none is needed: every item leaves on schedule.
module light_radius_color_envelope_unit
  import lrce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output out_item_t result_o
);

  localparam logic [1:0] RF_ONE  = 2'd0;
  localparam logic [1:0] RF_EXP  = 2'd1;
  localparam logic [1:0] RF_GROW = 2'd2;
  localparam logic [1:0] RF_FADE = 2'd3;

  typedef struct packed {
    logic [1:0]       rsel;
    logic             ra_zero;
    logic             cgrow;
    logic             scale_en;
    logic [RAD_W-1:0] trad;
    logic [RAD_W-1:0] srad;
    logic [COL_W-1:0] tr, tg, tb, sr, sg, sb;
  } side_t;

  logic [PIPE_LAT-1:0] vld_q;
  in_item_t            item_q;

  assign busy_o = 1'b0;

  // Travel the valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
  end

  // Form numerators and divisors, each numerator clamped to its divisor
  logic [16:0] rem, fade17, peak17, total, over, gmin, rmin, gnum, enum_n, fnum;
  logic        in_peak;
  side_t       side_d;

  always_comb begin
    rem     = item_q.remaining_time;
    fade17  = {1'b0, item_q.fade_time};
    peak17  = {1'b0, item_q.peak_time};
    total   = fade17 + peak17;
    in_peak = rem > fade17;
    over    = rem - fade17;
    gmin    = (over > peak17) ? peak17 : over;
    gnum    = peak17 - gmin;
    rmin    = (rem > total) ? total : rem;
    enum_n  = total - rmin;
    fnum    = (rem > fade17) ? fade17 : rem;

    side_d.trad = item_q.target_radius;
    side_d.srad = item_q.start_radius;
    side_d.tr   = item_q.target_red;
    side_d.tg   = item_q.target_green;
    side_d.tb   = item_q.target_blue;
    side_d.sr   = item_q.start_red;
    side_d.sg   = item_q.start_green;
    side_d.sb   = item_q.start_blue;

    if (total == '0) begin
      side_d.rsel = RF_ONE;
    end else if (item_q.mode_flags[FLAG_EXPAND]) begin
      side_d.rsel = RF_EXP;
    end else if (!item_q.mode_flags[FLAG_FLASH] && in_peak) begin
      side_d.rsel = RF_GROW;
    end else if (item_q.mode_flags[FLAG_SHRINK]) begin
      side_d.rsel = RF_FADE;
    end else begin
      side_d.rsel = RF_ONE;
    end
    side_d.ra_zero  = (side_d.rsel == RF_FADE);
    side_d.cgrow    = !item_q.mode_flags[FLAG_FLASH] && (peak17 != '0) && in_peak;
    side_d.scale_en = (fade17 != '0) && (rem < fade17);
  end

  // Three fraction dividers
  logic [FRAC_W-1:0] exp_f, grow_f, fade_f;

  lrce_div u_div_exp (
    .clk_i (clk_i), .num_i (enum_n), .den_i (total),  .quo_o (exp_f)
  );
  lrce_div u_div_grow (
    .clk_i (clk_i), .num_i (gnum),   .den_i (peak17), .quo_o (grow_f)
  );
  lrce_div u_div_fade (
    .clk_i (clk_i), .num_i (fnum),   .den_i (fade17), .quo_o (fade_f)
  );

  // Hold the side data for the divider latency
  side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  side_t             sd;
  logic [FRAC_W-1:0] rf, cf, ff;
  logic [RAD_W-1:0]  ra;

  // Pick the fractions for this item
  always_comb begin
    sd = side_q[DIV_LAT-1];
    case (sd.rsel)
      RF_EXP:  rf = exp_f;
      RF_GROW: rf = grow_f;
      RF_FADE: rf = fade_f;
      default: rf = ONE_Q16;
    endcase
    ra = sd.ra_zero ? '0 : sd.srad;
    cf = sd.cgrow ? grow_f : ONE_Q16;
    ff = sd.scale_en ? fade_f : ONE_Q16;
  end

  // Interpolate radius and color
  logic [RAD_W-1:0] rad_a, red_a, grn_a, blu_a;

  lrce_lerp u_lerp_rad (
    .clk_i (clk_i), .a_i (ra), .b_i (sd.trad), .f_i (rf), .y_o (rad_a)
  );
  lrce_lerp u_lerp_red (
    .clk_i (clk_i), .a_i ({4'd0, sd.sr}), .b_i ({4'd0, sd.tr}), .f_i (cf), .y_o (red_a)
  );
  lrce_lerp u_lerp_grn (
    .clk_i (clk_i), .a_i ({4'd0, sd.sg}), .b_i ({4'd0, sd.tg}), .f_i (cf), .y_o (grn_a)
  );
  lrce_lerp u_lerp_blu (
    .clk_i (clk_i), .a_i ({4'd0, sd.sb}), .b_i ({4'd0, sd.tb}), .f_i (cf), .y_o (blu_a)
  );

  // Hold the fade fraction while interpolation runs
  logic [FRAC_W-1:0] ff_q [LERP_LAT];

  always_ff @(posedge clk_i) begin
    ff_q[0] <= ff;
    for (int i = 1; i < LERP_LAT; i++) begin
      ff_q[i] <= ff_q[i-1];
    end
  end

  // Scale color by the fade fraction; pass radius through at one
  logic [RAD_W-1:0] rad_b, red_b, grn_b, blu_b;

  lrce_lerp u_scale_rad (
    .clk_i (clk_i), .a_i ('0), .b_i (rad_a), .f_i (ONE_Q16), .y_o (rad_b)
  );
  lrce_lerp u_scale_red (
    .clk_i (clk_i), .a_i ('0), .b_i (red_a), .f_i (ff_q[LERP_LAT-1]), .y_o (red_b)
  );
  lrce_lerp u_scale_grn (
    .clk_i (clk_i), .a_i ('0), .b_i (grn_a), .f_i (ff_q[LERP_LAT-1]), .y_o (grn_b)
  );
  lrce_lerp u_scale_blu (
    .clk_i (clk_i), .a_i ('0), .b_i (blu_a), .f_i (ff_q[LERP_LAT-1]), .y_o (blu_b)
  );

  assign done_o              = vld_q[PIPE_LAT-1];
  assign result_o.cur_radius = rad_b;
  assign result_o.cur_red    = red_b[COL_W-1:0];
  assign result_o.cur_green  = grn_b[COL_W-1:0];
  assign result_o.cur_blue   = blu_b[COL_W-1:0];

endmodule

### design/lrce_checker.sv
`include "assert_macros.svh"

module lrce_checker
  import lrce_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input in_item_t  item_i,
  input logic      busy_o,
  input logic      done_o,
  input out_item_t result_o
);

  // The unit never refuses an item
  `ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)

  // Every result answers an item taken a fixed latency earlier
  `ASSERT_AT(a_done_has_item, clk_i, rst_ni, done_o |-> $past(start_i, PIPE_LAT))

  // With no phases at all the radius is the target radius
  `ASSERT_AT(a_zero_life_radius, clk_i, rst_ni, (done_o && $past(item_i.fade_time == '0 && item_i.peak_time == '0, PIPE_LAT)) |-> (result_o.cur_radius == $past(item_i.target_radius, PIPE_LAT)))

endmodule

bind light_radius_color_envelope_unit lrce_checker u_lrce_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .item_i   (item_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);
